>>> sv/assert_macros.svh
// Assertion helpers for the rational arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that antecedent implies consequent on the same edge
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that antecedent implies consequent on the next edge
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/rau_pkg.sv
package rau_pkg;

  localparam int unsigned OperandWidth = 31;
  localparam int unsigned ProdWidth    = 2 * OperandWidth;
  localparam int unsigned WideWidth    = 64;
  localparam int unsigned MagWidth     = 63;
  localparam int unsigned QDepth       = 2;
  localparam int unsigned QPtrWidth    = $clog2(QDepth);

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef logic signed [OperandWidth-1:0] operand_t;

  // classified job handed from front to back
  typedef struct packed {
    logic                 special;
    logic                 div_zero;
    logic                 neg;
    logic [MagWidth:0]    unum;
    logic [MagWidth:0]    uden;
  } job_t;

  typedef struct packed {
    logic signed [WideWidth-1:0] res_num;
    logic [MagWidth-1:0]         res_den;
    logic                        div_zero;
  } result_t;

endpackage

>>> sv/rau_front.sv
module rau_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action_i,
  input  rau_pkg::operand_t   a_num_i,
  input  rau_pkg::operand_t   a_den_i,
  input  rau_pkg::operand_t   b_num_i,
  input  rau_pkg::operand_t   b_den_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output rau_pkg::job_t       job_o
);

  typedef enum logic [1:0] {
    StIdle,
    StMul1,
    StMul2,
    StSign
  } state_e;

  state_e state_q;
  rau_pkg::op_e op_q;
  rau_pkg::operand_t an_q, ad_q, bn_q, bd_q;
  logic signed [rau_pkg::ProdWidth-1:0] p1_q, p2_q, dp_q;
  logic signed [rau_pkg::WideWidth-1:0] num_q;
  logic signed [rau_pkg::WideWidth-1:0] den_q;
  logic dz_q;
  logic out_valid_q;
  logic stage_q;
  rau_pkg::job_t job_q;

  rau_pkg::operand_t m1_a, m1_b, m2_a, m2_b;
  logic signed [rau_pkg::ProdWidth-1:0] m1, m2;
  logic signed [rau_pkg::WideWidth-1:0] num_w, den_w, num_s, den_s;
  logic [rau_pkg::WideWidth-1:0] nmag;

  assign full        = (state_q != StIdle) || stage_q || out_valid_q;
  assign job_valid_o = out_valid_q;
  assign job_o       = job_q;

  always_comb begin
    m1_a = an_q;
    m1_b = bd_q;
    m2_a = bn_q;
    m2_b = ad_q;
    if (state_q == StMul2) begin
      m1_a = ad_q;
      m1_b = (op_q == rau_pkg::OpDiv) ? bn_q : bd_q;
      m2_a = an_q;
      m2_b = bn_q;
    end
    m1 = rau_pkg::ProdWidth'(m1_a) * rau_pkg::ProdWidth'(m1_b);
    m2 = rau_pkg::ProdWidth'(m2_a) * rau_pkg::ProdWidth'(m2_b);
  end

  always_comb begin
    den_w = rau_pkg::WideWidth'(dp_q);
    case (op_q)
      rau_pkg::OpAdd: num_w = rau_pkg::WideWidth'(p1_q) + rau_pkg::WideWidth'(p2_q);
      rau_pkg::OpSub: num_w = rau_pkg::WideWidth'(p1_q) - rau_pkg::WideWidth'(p2_q);
      rau_pkg::OpMul: num_w = rau_pkg::WideWidth'(p2_q);
      default:        num_w = rau_pkg::WideWidth'(p1_q);
    endcase
  end

  always_comb begin
    num_s = num_q;
    den_s = den_q;
    if (den_q < 0) begin
      num_s = -num_q;
      den_s = -den_q;
    end
    nmag = num_s[rau_pkg::WideWidth-1] ? rau_pkg::WideWidth'(-num_s)
                                       : rau_pkg::WideWidth'(num_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (push && !full) begin
            op_q    <= rau_pkg::op_e'(action_i);
            an_q    <= a_num_i;
            ad_q    <= a_den_i;
            bn_q    <= b_num_i;
            bd_q    <= b_den_i;
            dz_q    <= (action_i == rau_pkg::OpDiv) && (b_num_i == '0);
            state_q <= StMul1;
          end
        end
        StMul1: begin
          p1_q    <= m1;
          p2_q    <= m2;
          state_q <= StMul2;
        end
        StMul2: begin
          dp_q <= m1;
          if (op_q == rau_pkg::OpMul) begin
            p2_q <= m2;
          end
          state_q <= StSign;
        end
        StSign: begin
          num_q   <= num_w;
          den_q   <= den_w;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // sign fix and classify from the registered sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q <= (state_q == StSign);
      if (stage_q) begin
        out_valid_q       <= 1'b1;
        job_q.div_zero    <= dz_q;
        job_q.special     <= dz_q || (num_s == '0);
        job_q.neg         <= num_s[rau_pkg::WideWidth-1];
        job_q.unum        <= nmag;
        job_q.uden        <= rau_pkg::WideWidth'(den_s);
      end else if (out_valid_q && job_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> sv/rau_queue.sv
module rau_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  output logic          wr_ready_o,
  input  rau_pkg::job_t wdata_i,
  output logic          rd_valid_o,
  input  logic          rd_i,
  output rau_pkg::job_t rdata_o
);

  rau_pkg::job_t mem_q [rau_pkg::QDepth];
  logic [rau_pkg::QPtrWidth-1:0] wp_q, rp_q;
  logic [rau_pkg::QPtrWidth:0]   cnt_q;

  assign wr_ready_o = (cnt_q != rau_pkg::QPtrWidth'(0) + (rau_pkg::QPtrWidth+1)'(rau_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rdata_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && wr_ready_o) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && wr_ready_o) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd_i && rd_valid_o) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (rau_pkg::QPtrWidth+1)'(wr_i && wr_ready_o)
                     - (rau_pkg::QPtrWidth+1)'(rd_i && rd_valid_o);
    end
  end

endmodule

>>> sv/rau_back.sv
module rau_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_take_o,
  input  rau_pkg::job_t    job_i,
  output logic             empty,
  input  logic             pop,
  output rau_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    StIdle,
    StGcd,
    StDivN,
    StDivD,
    StDone
  } state_e;

  localparam int unsigned W = rau_pkg::MagWidth + 1;
  localparam int unsigned CW = $clog2(W + 1);

  state_e state_q;
  logic [W-1:0] x_q, y_q, g_q, n_q, d_q;
  logic [W-1:0] quo_q, rem_q, dvd_q;
  logic [CW-1:0] cnt_q;
  logic neg_q;
  logic first_q;
  rau_pkg::result_t res_q;

  // one restoring divide step
  logic [W:0] rem_full;
  logic [W-1:0] divisor;
  logic ge;
  always_comb begin
    divisor  = (state_q == StGcd) ? y_q : g_q;
    rem_full = {rem_q, dvd_q[W-1]};
    ge       = rem_full >= {1'b0, divisor};
  end

  assign job_take_o = (state_q == StIdle) && job_valid_i;
  assign empty      = (state_q != StDone);
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            res_q.div_zero <= job_i.div_zero;
            if (job_i.special) begin
              res_q.res_num <= '0;
              res_q.res_den <= rau_pkg::MagWidth'(1);
              state_q       <= StDone;
            end else begin
              neg_q   <= job_i.neg;
              n_q     <= job_i.unum;
              d_q     <= job_i.uden;
              x_q     <= job_i.unum;
              y_q     <= job_i.uden;
              first_q <= 1'b1;
              state_q <= StGcd;
            end
          end
        end
        StGcd: begin
          if (first_q) begin
            first_q <= 1'b0;
            if (y_q == '0) begin
              g_q     <= x_q;
              dvd_q   <= n_q;
              rem_q   <= '0;
              cnt_q   <= CW'(W);
              state_q <= StDivN;
            end else begin
              dvd_q <= x_q;
              rem_q <= '0;
              cnt_q <= CW'(W);
            end
          end else if (cnt_q != '0) begin
            rem_q <= ge ? W'(rem_full - {1'b0, divisor}) : rem_full[W-1:0];
            dvd_q <= {dvd_q[W-2:0], 1'b0};
            cnt_q <= cnt_q - 1'b1;
          end else begin
            x_q     <= y_q;
            y_q     <= rem_q;
            first_q <= 1'b1;
          end
        end
        StDivN, StDivD: begin
          if (cnt_q != '0) begin
            rem_q <= ge ? W'(rem_full - {1'b0, divisor}) : rem_full[W-1:0];
            quo_q <= {quo_q[W-2:0], ge};
            dvd_q <= {dvd_q[W-2:0], 1'b0};
            cnt_q <= cnt_q - 1'b1;
          end else if (state_q == StDivN) begin
            res_q.res_num <= neg_q ? rau_pkg::WideWidth'(-quo_q)
                                   : rau_pkg::WideWidth'(quo_q);
            dvd_q   <= d_q;
            rem_q   <= '0;
            cnt_q   <= CW'(W);
            state_q <= StDivD;
          end else begin
            res_q.res_den <= quo_q[rau_pkg::MagWidth-1:0];
            state_q       <= StDone;
          end
        end
        StDone: begin
          if (pop) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: combines two fractions by add, subtract, multiply
// or divide and returns the result in lowest terms with a positive denominator
// (zero gives 0/1; divide by a zero fraction gives 0/1 with div_zero set).
// The front end goes from accept through two cross-product steps, the sum
// and the sign fix to handing the word to the queue, and holds full high until
// the queue takes it. The back end runs Euclid with a one-bit-per-cycle
// restoring divider over 64 bits for each remainder step and then two
// divisions by the gcd; zero and divide-by-zero results skip both.
// The count of gcd remainder steps, up to about 90, sets an item's run time.
// A two-entry queue separates the two parts.
`include "assert_macros.svh"

module rational_arithmetic_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push,
  output logic                                    full,
  input  logic [1:0]                              action_i,
  input  logic signed [rau_pkg::OperandWidth-1:0] a_num_i,
  input  logic signed [rau_pkg::OperandWidth-1:0] a_den_i,
  input  logic signed [rau_pkg::OperandWidth-1:0] b_num_i,
  input  logic signed [rau_pkg::OperandWidth-1:0] b_den_i,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [63:0]                      res_num_o,
  output logic [62:0]                             res_den_o,
  output logic                                    div_zero_o
);

  logic          f_valid, q_ready, q_valid, b_take;
  rau_pkg::job_t f_job, q_job;
  rau_pkg::result_t res;

  rau_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .action_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .job_valid_o(f_valid), .job_ready_i(q_ready), .job_o(f_job)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i(f_valid), .wr_ready_o(q_ready), .wdata_i(f_job),
    .rd_valid_o(q_valid), .rd_i(b_take), .rdata_o(q_job)
  );

  rau_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_take_o(b_take), .job_i(q_job),
    .empty, .pop, .res_o(res)
  );

  assign res_num_o  = res.res_num;
  assign res_den_o  = res.res_den;
  assign div_zero_o = res.div_zero;

  `RAU_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, !empty && div_zero_o, res_num_o == '0)
  `RAU_ASSERT_IMP(a_zero_den1, clk_i, rst_ni, !empty && res_num_o == '0, res_den_o == 63'd1)
  `RAU_ASSERT_NEXT(a_pop_clr, clk_i, rst_ni, !empty && pop, empty)

endmodule
